// File: src/mcps_pkg.sv
package mcps_pkg;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [15:0] RESET_PERIOD_MS = 16'd500;
    localparam logic [7:0]  RESET_ON_DUTY   = 8'd255;  // 100 percent
    localparam logic [7:0]  DUTY_MAX        = 8'd255;

    // x/100 as (x * 5243) >> 19, exact for x < 2^15
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_SHIFT     = 19;

    typedef struct packed {
        logic        opcode;
        logic [31:0] time_ms;
        logic [3:0]  channel;
        logic        enable;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
        logic [6:0]  intensity_pct;
    } in_item_t;

    typedef struct packed {
        logic [3:0] out_channel;
        logic [7:0] duty;
        logic       motor_on;
        logic       last;
    } out_item_t;

    // Per-channel settings; on_duty is precomputed from the intensity at write.
    typedef struct packed {
        logic        enable;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
        logic [7:0]  on_duty;
    } cfg_rec_t;

    // Per-channel running state.
    typedef struct packed {
        logic        phase_on;
        logic [7:0]  duty;
        logic [31:0] toggle_time;
    } st_rec_t;

    function automatic logic [7:0] pct_to_duty(input logic [6:0] pct);
        logic [14:0] scaled;
        logic [27:0] prod;
        logic [8:0]  quot;
        scaled = {pct, 8'b0} - 15'(pct);
        prod   = 28'(scaled) * 28'(RECIP_100);
        quot   = prod[RECIP_SHIFT +: 9];
        return (quot > 9'(DUTY_MAX)) ? DUTY_MAX : quot[7:0];
    endfunction

endpackage

// File: src/multi_channel_pulse_scheduler.sv
// Channel   Beat type              Handshake             Direction
// item      mcps_pkg::in_item_t    item_valid/stall      into block
// result    mcps_pkg::out_item_t   result_valid/stall    out of block
//
// A write beat is taken while idle and gives no result.
// A tick walks CHANNELS channels through the shared toggle unit, one per cycle
// while the result side does not stall, behind a registered read of the channel
// stores. item_stall stays high for the walk.
// Reset clears the store valid bits at once; no clearing pass.
// A stall on result freezes the walk on the current channel.
module multi_channel_pulse_scheduler #(
    parameter int CHANNELS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  mcps_pkg::in_item_t    item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output mcps_pkg::out_item_t   result
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);
    localparam logic [AW-1:0] LAST_IDX = AW'(CHANNELS - 1);

    typedef enum logic {
        S_IDLE,
        S_CALC
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [31:0]         time_reg, time_next;
    logic                result_valid_reg, result_valid_next;
    mcps_pkg::out_item_t result_reg, result_next;

    logic               accept;
    logic               tick_go;
    logic               advance;
    logic               at_last;
    logic [6:0]         ch_wide;
    logic [6:0]         idx_wide;
    logic               cfg_we;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    mcps_pkg::cfg_rec_t cfg_wdata;
    mcps_pkg::cfg_rec_t cfg_rd;
    mcps_pkg::st_rec_t  st_rd;
    mcps_pkg::st_rec_t  st_new;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign tick_go    = accept && (item.opcode == mcps_pkg::OP_TICK);

    assign ch_wide  = 7'(item.channel);
    assign cfg_we   = accept && (item.opcode == mcps_pkg::OP_WRITE) && (ch_wide < CH_LIMIT);

    always_comb
    begin
        cfg_wdata.enable  = item.enable;
        cfg_wdata.on_ms   = item.on_ms;
        cfg_wdata.off_ms  = item.off_ms;
        cfg_wdata.on_duty = mcps_pkg::pct_to_duty(item.intensity_pct);
    end

    assign at_last  = (idx_reg == LAST_IDX);
    assign advance  = (state_reg == S_CALC) && (!result_valid_reg || !result_stall);
    assign rd_en    = tick_go || (advance && !at_last);
    assign rd_addr  = (state_reg == S_IDLE) ? '0 : idx_reg + AW'(1);
    assign idx_wide = 7'(idx_reg);

    mcps_cfg_mem #(
        .DEPTH (CHANNELS)
    ) u_cfg_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .waddr (ch_wide[AW-1:0]),
        .wdata (cfg_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (cfg_rd)
    );

    mcps_state_mem #(
        .DEPTH (CHANNELS)
    ) u_state_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (advance),
        .waddr (idx_reg),
        .wdata (st_new),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (st_rd)
    );

    mcps_toggle_unit u_toggle (
        .now (time_reg),
        .cfg (cfg_rd),
        .cur (st_rd),
        .nxt (st_new)
    );

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        time_next         = time_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (tick_go)
                begin
                    state_next = S_CALC;
                    idx_next   = '0;
                    time_next  = item.time_ms;
                end
            end
            S_CALC:
            begin
                if (advance)
                begin
                    result_valid_next       = 1'b1;
                    result_next.out_channel = idx_wide[3:0];
                    result_next.duty        = st_new.duty;
                    result_next.motor_on    = st_new.phase_on;
                    result_next.last        = at_last;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            time_reg         <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            time_reg         <= time_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // off phase always drives zero duty
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.motor_on |-> result.duty == 8'd0)
        else $error("off-phase beat with nonzero duty");

    // a non-final beat on the output means the walk is still running
    a_walk_open: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> state_reg == S_CALC)
        else $error("walk ended before final channel");

    // a tick starts the walk at channel zero
    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        tick_go |=> state_reg == S_CALC && idx_reg == '0)
        else $error("tick did not start walk at channel zero");

    // settings never change under a running walk
    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> state_reg == S_IDLE && !$past(advance && !at_last))
        else $error("settings write during walk");

endmodule

// File: src/mcps_cfg_mem.sv
module mcps_cfg_mem #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  mcps_pkg::cfg_rec_t       wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output mcps_pkg::cfg_rec_t       rdata
);

    mcps_pkg::cfg_rec_t mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic               rd_valid_reg;
    mcps_pkg::cfg_rec_t rd_data_reg;
    mcps_pkg::cfg_rec_t reset_rec;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    always_comb
    begin
        reset_rec.enable  = 1'b0;
        reset_rec.on_ms   = mcps_pkg::RESET_PERIOD_MS;
        reset_rec.off_ms  = mcps_pkg::RESET_PERIOD_MS;
        reset_rec.on_duty = mcps_pkg::RESET_ON_DUTY;
    end

    // never-written entries read as their reset settings
    assign rdata = rd_valid_reg ? rd_data_reg : reset_rec;

endmodule

// File: src/mcps_state_mem.sv
module mcps_state_mem #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  mcps_pkg::st_rec_t        wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output mcps_pkg::st_rec_t        rdata
);

    mcps_pkg::st_rec_t mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;
    mcps_pkg::st_rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    // untouched channels: off phase, duty 0, toggle time 0
    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: src/mcps_toggle_unit.sv
module mcps_toggle_unit (
    input  logic [31:0]          now,
    input  mcps_pkg::cfg_rec_t   cfg,
    input  mcps_pkg::st_rec_t    cur,
    output mcps_pkg::st_rec_t    nxt
);

    logic [31:0] elapsed;
    logic [15:0] period;
    logic        expired;

    // one wrapping subtract and one compare, shared by both phases
    assign elapsed = now - cur.toggle_time;
    assign period  = cur.phase_on ? cfg.on_ms : cfg.off_ms;
    assign expired = elapsed >= 32'(period);

    always_comb
    begin
        nxt = cur;
        if (!cfg.enable)
        begin
            nxt.phase_on = 1'b0;
            nxt.duty     = '0;
        end
        else if (expired)
        begin
            nxt.phase_on    = !cur.phase_on;
            nxt.duty        = cur.phase_on ? 8'd0 : cfg.on_duty;
            nxt.toggle_time = now;
        end
    end

endmodule

// File: tb/multi_channel_pulse_scheduler_test.sv
module multi_channel_pulse_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS    = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 2 * CHANNELS + 8;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    mcps_pkg::in_item_t  item         = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    mcps_pkg::out_item_t result;

    multi_channel_pulse_scheduler #(
        .CHANNELS(CHANNELS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    // Scheduler shadow state
    logic        ch_enable   [CHANNELS];
    logic [15:0] ch_on_ms    [CHANNELS];
    logic [15:0] ch_off_ms   [CHANNELS];
    logic [6:0]  ch_pct      [CHANNELS];
    logic        ch_phase_on [CHANNELS];
    logic [31:0] ch_toggled  [CHANNELS];
    logic [7:0]  ch_duty     [CHANNELS];

    mcps_pkg::in_item_t  pending_beats[$];
    mcps_pkg::out_item_t expected_pulses[$];

    int total_items    = 0;
    int beats_accepted = 0;
    int writes_taken   = 0;
    int ticks_taken    = 0;
    int pulses_checked = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    function automatic logic [7:0] percent_to_duty(input logic [6:0] pct);
        int unsigned scaled;
        scaled = (32'(pct) * 255) / 100;
        return (scaled > 255) ? 8'hFF : scaled[7:0];
    endfunction

    function automatic void store_channel_settings(input mcps_pkg::in_item_t beat);
        if (32'(beat.channel) < CHANNELS) begin
            ch_enable[beat.channel] = beat.enable;
            ch_on_ms[beat.channel]  = beat.on_ms;
            ch_off_ms[beat.channel] = beat.off_ms;
            ch_pct[beat.channel]    = beat.intensity_pct;
        end
    endfunction

    function automatic void advance_channels(input logic [31:0] now_ms);
        logic [31:0]         elapsed;
        mcps_pkg::out_item_t pulse;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            elapsed = now_ms - ch_toggled[ch];
            if (!ch_enable[ch]) begin
                // disabled: forced off, toggle time kept
                ch_duty[ch]     = 8'd0;
                ch_phase_on[ch] = 1'b0;
            end else if (ch_phase_on[ch]) begin
                if (elapsed >= 32'(ch_on_ms[ch])) begin
                    ch_duty[ch]     = 8'd0;
                    ch_phase_on[ch] = 1'b0;
                    ch_toggled[ch]  = now_ms;
                end
            end else if (elapsed >= 32'(ch_off_ms[ch])) begin
                ch_duty[ch]     = percent_to_duty(ch_pct[ch]);
                ch_phase_on[ch] = 1'b1;
                ch_toggled[ch]  = now_ms;
            end
            pulse.out_channel = 4'(ch);
            pulse.duty        = ch_duty[ch];
            pulse.motor_on    = ch_phase_on[ch];
            pulse.last        = (ch == CHANNELS - 1);
            expected_pulses.push_back(pulse);
        end
    endfunction

    function automatic mcps_pkg::in_item_t make_tick(input logic [31:0] now_ms);
        mcps_pkg::in_item_t beat;
        beat.opcode        = mcps_pkg::OP_TICK;
        beat.time_ms       = now_ms;
        beat.channel       = 4'($urandom);
        beat.enable        = 1'($urandom);
        beat.on_ms         = 16'($urandom);
        beat.off_ms        = 16'($urandom);
        beat.intensity_pct = 7'($urandom);
        return beat;
    endfunction

    function automatic mcps_pkg::in_item_t make_write(input logic [3:0] ch, input logic en,
                                                      input logic [15:0] on_ms,
                                                      input logic [15:0] off_ms,
                                                      input logic [6:0] pct);
        mcps_pkg::in_item_t beat;
        beat.opcode        = mcps_pkg::OP_WRITE;
        beat.time_ms       = $urandom;
        beat.channel       = ch;
        beat.enable        = en;
        beat.on_ms         = on_ms;
        beat.off_ms        = off_ms;
        beat.intensity_pct = pct;
        return beat;
    endfunction

    // mostly short periods so channels toggle often
    function automatic logic [15:0] pick_period();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return 16'($urandom_range(40));
        if (roll < 95)
            return 16'($urandom);
        return (roll < 97) ? 16'h0000 : 16'hFFFF;
    endfunction

    function automatic int idle_stage();
        return (beats_accepted * 3) / total_items;
    endfunction

    function automatic int send_idle_pct();
        case (idle_stage())
            0:       return 11;
            1:       return 73;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (idle_stage())
            0:       return 73;
            1:       return 11;
            default: return 0;
        endcase
    endfunction

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // item driver; predicts on each accepted beat
    always @(posedge clk) begin
        if (!rst_n) begin
            item_valid <= 1'b0;
        end else begin
            if (item_valid && !item_stall) begin
                if (item.opcode == mcps_pkg::OP_WRITE) begin
                    store_channel_settings(item);
                    writes_taken++;
                end else begin
                    advance_channels(item.time_ms);
                    ticks_taken++;
                end
                beats_accepted++;
            end
            if (!item_valid || !item_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
                    item       <= pending_beats.pop_front();
                    item_valid <= 1'b1;
                end else begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        result_stall <= ($urandom_range(99) < recv_idle_pct());
    end

    // result monitor
    always @(posedge clk) begin
        mcps_pkg::out_item_t want;
        if (rst_n && result_valid && !result_stall) begin
            if (expected_pulses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: ch=%0d duty=%0d on=%0d last=%0d",
                             result.out_channel, result.duty, result.motor_on, result.last);
            end else begin
                want = expected_pulses.pop_front();
                pulses_checked++;
                if (result.out_channel !== want.out_channel || result.duty !== want.duty ||
                    result.motor_on !== want.motor_on || result.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: got ch=%0d duty=%0d on=%0d last=%0d,",
                                 result.out_channel, result.duty, result.motor_on,
                                 result.last);
                        $display("  want ch=%0d duty=%0d on=%0d last=%0d",
                                 want.out_channel, want.duty, want.motor_on, want.last);
                    end
                end
            end
        end
    end

    initial begin
        logic [31:0] now_ms;
        int          roll;

        for (int ch = 0; ch < CHANNELS; ch++) begin
            ch_enable[ch]   = 1'b0;
            ch_on_ms[ch]    = 16'd500;
            ch_off_ms[ch]   = 16'd500;
            ch_pct[ch]      = 7'd100;
            ch_phase_on[ch] = 1'b0;
            ch_toggled[ch]  = 32'd0;
            ch_duty[ch]     = 8'd0;
        end

        // directed: reset defaults, zero and max periods, saturating percent,
        // settings change while off, disable mid-phase, time wrap
        pending_beats.push_back(make_tick(32'd0));
        pending_beats.push_back(make_write(4'd0, 1'b1, 16'd0, 16'd0, 7'd100));
        pending_beats.push_back(make_write(4'd15, 1'b1, 16'hFFFF, 16'hFFFF, 7'd127));
        pending_beats.push_back(make_write(4'd1, 1'b1, 16'd3, 16'd2, 7'd0));
        pending_beats.push_back(make_write(4'd2, 1'b1, 16'd500, 16'd500, 7'd1));
        pending_beats.push_back(make_write(4'd3, 1'b0, 16'd10, 16'd10, 7'd50));
        pending_beats.push_back(make_write(4'd7, 1'b1, 16'd1, 16'd1, 7'd101));
        pending_beats.push_back(make_tick(32'd0));
        pending_beats.push_back(make_tick(32'd1));
        pending_beats.push_back(make_write(4'd0, 1'b1, 16'd0, 16'd0, 7'd37));
        pending_beats.push_back(make_tick(32'd2));
        pending_beats.push_back(make_tick(32'd5));
        pending_beats.push_back(make_write(4'd2, 1'b0, 16'd500, 16'd500, 7'd1));
        pending_beats.push_back(make_tick(32'hFFFF_FFF0));
        pending_beats.push_back(make_tick(32'h0000_0005));
        pending_beats.push_back(make_write(4'd2, 1'b1, 16'd500, 16'd500, 7'd100));
        pending_beats.push_back(make_tick(32'hFFFF_FFFF));
        pending_beats.push_back(make_tick(32'h8000_0000));
        pending_beats.push_back(make_tick(32'h8000_0000));

        now_ms = 32'h8000_0000;
        for (int n = 0; n < 450; n++) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
                pending_beats.push_back(make_write(4'($urandom), ($urandom_range(9) != 0),
                    pick_period(), pick_period(),
                    ($urandom_range(9) == 0) ? 7'($urandom_range(127, 101))
                                             : 7'($urandom_range(100))));
            end else begin
                if (roll < 92)
                    now_ms = now_ms + $urandom_range(30);
                else if (roll < 97)
                    now_ms = now_ms + $urandom;
                else
                    now_ms = $urandom;
                pending_beats.push_back(make_tick(now_ms));
            end
        end
        total_items = pending_beats.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while ((pending_beats.size() != 0 || item_valid || expected_pulses.size() != 0) &&
               cycle_count < CYCLE_LIMIT)
            @(negedge clk);

        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d result beats outstanding",
                     cycle_count, expected_pulses.size());
            $display("Mismatches found");
        end else begin
            repeat (DRAIN) @(negedge clk);
            if (expected_pulses.size() != 0) begin
                $display("%0d result beats never arrived", expected_pulses.size());
                mismatches += expected_pulses.size();
            end
            $display("%0d item beats taken (%0d writes, %0d ticks), %0d result beats checked",
                     beats_accepted, writes_taken, ticks_taken, pulses_checked);
            $display("stress: stalls on both sides, wrapping time, saturated duty, %0d cycles",
                     cycle_count);
            if (mismatches == 0)
                $display("No mismatches found");
            else
                $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: multi_channel_pulse_scheduler.f
src/mcps_pkg.sv
src/mcps_cfg_mem.sv
src/mcps_state_mem.sv
src/mcps_toggle_unit.sv
src/multi_channel_pulse_scheduler.sv
tb/multi_channel_pulse_scheduler_test.sv
